@@ design/mts_pkg.sv @@
`timescale 1ns / 1ps

package mts_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 256;

    // tuser bit positions on the result side
    localparam int OUT_USER_W = 3;
    localparam int USER_OK    = 0;
    localparam int USER_MINV  = 1;
    localparam int USER_OVF   = 2;

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } t_kind;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } t_state;

endpackage

@@ design/mts_store.sv @@
`timescale 1ns / 1ps

module mts_store #(
    parameter int DEPTH = mts_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [AW-1:0]                     i_wr_addr,
    input  logic signed [mts_pkg::DATA_W-1:0] i_wr_val,
    input  logic signed [mts_pkg::DATA_W-1:0] i_wr_min,
    input  logic                              i_rd_en,
    input  logic [AW-1:0]                     i_rd_addr,
    output logic signed [mts_pkg::DATA_W-1:0] o_rd_val,
    output logic signed [mts_pkg::DATA_W-1:0] o_rd_min
);
    import mts_pkg::*;

    logic signed [DATA_W-1:0] r_val_mem [DEPTH];
    logic signed [DATA_W-1:0] r_min_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rd_val;
    logic signed [DATA_W-1:0] r_rd_min;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_val_mem[i_wr_addr] <= i_wr_val;
            r_min_mem[i_wr_addr] <= i_wr_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_val <= r_val_mem[i_rd_addr];
            r_rd_min <= r_min_mem[i_rd_addr];
        end
    end

    assign o_rd_val = r_rd_val;
    assign o_rd_min = r_rd_min;

endmodule

@@ design/min_tracking_stack.sv @@
`timescale 1ns / 1ps
// Channel   Dir  tdata (low bit up)                   tuser (low bit up)
// s_axis    in   push_value[31:0]                     kind
// m_axis    out  popped_value[31:0], min_value[31:0]  ok, min_valid, overflow
//
// A push, or a pop on an empty stack, is answered from ST_IDLE. A pop that
// finds an entry passes through ST_POP, where no request is taken: the entry
// below the top comes out of the store, whose read is registered. The top
// entry and its minimum live in registers. Reset clears the state, the entry
// count and the result valid; the store needs no clearing pass.
// A request is taken while a result waits, provided that result leaves in
// the same cycle.

module min_tracking_stack #(
    parameter int DEPTH = mts_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [mts_pkg::DATA_W-1:0]          i_s_axis_tdata,  // push_value
    input  logic [0:0]                          i_s_axis_tuser,  // kind
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [2*mts_pkg::DATA_W-1:0]        o_m_axis_tdata,  // popped_value, min_value
    output logic [mts_pkg::OUT_USER_W-1:0]      o_m_axis_tuser   // ok, min_valid, overflow
);
    import mts_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic signed [DATA_W-1:0] r_top_val, n_top_val;
    logic signed [DATA_W-1:0] r_top_min, n_top_min;

    logic                     r_out_valid, n_out_valid;
    logic                     r_out_ok, n_out_ok;
    logic signed [DATA_W-1:0] r_out_pop, n_out_pop;
    logic signed [DATA_W-1:0] r_out_min, n_out_min;
    logic                     r_out_minv, n_out_minv;
    logic                     r_out_ovf, n_out_ovf;

    logic                     s_ready;
    logic                     wr_en;
    logic                     rd_en;
    logic [CW-1:0]            wr_cnt;
    logic [CW-1:0]            rd_cnt;
    logic signed [DATA_W-1:0] push_val;
    logic signed [DATA_W-1:0] push_min;
    logic signed [DATA_W-1:0] rd_val;
    logic signed [DATA_W-1:0] rd_min;
    t_kind                    kind;

    assign push_val = $signed(i_s_axis_tdata);
    assign kind     = t_kind'(i_s_axis_tuser[0]);
    assign wr_cnt   = r_count - CW'(1);
    assign rd_cnt   = r_count - CW'(2);
    assign push_min = (r_count == '0 || push_val < r_top_min) ? push_val : r_top_min;

    mts_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_cnt[AW-1:0]),
        .i_wr_val  (r_top_val),
        .i_wr_min  (r_top_min),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_cnt[AW-1:0]),
        .o_rd_val  (rd_val),
        .o_rd_min  (rd_min)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_val  <= n_top_val;
        r_top_min  <= n_top_min;
        r_out_ok   <= n_out_ok;
        r_out_pop  <= n_out_pop;
        r_out_min  <= n_out_min;
        r_out_minv <= n_out_minv;
        r_out_ovf  <= n_out_ovf;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_top_val   = r_top_val;
        n_top_min   = r_top_min;
        n_out_valid = r_out_valid & ~i_m_axis_tready;
        n_out_ok    = r_out_ok;
        n_out_pop   = r_out_pop;
        n_out_min   = r_out_min;
        n_out_minv  = r_out_minv;
        n_out_ovf   = r_out_ovf;
        s_ready     = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                s_ready = ~r_out_valid | i_m_axis_tready;
                if (s_ready && i_s_axis_tvalid) begin
                    if (kind == KIND_PUSH) begin
                        n_out_valid = 1'b1;
                        n_out_pop   = '0;
                        if (r_count == CW'(DEPTH)) begin
                            // full: drop the push, report the unchanged stack
                            n_out_ok   = 1'b0;
                            n_out_ovf  = 1'b1;
                            n_out_min  = r_top_min;
                            n_out_minv = 1'b1;
                        end else begin
                            // spill the old top into the store
                            wr_en      = (r_count != '0);
                            n_top_val  = push_val;
                            n_top_min  = push_min;
                            n_count    = r_count + CW'(1);
                            n_out_ok   = 1'b1;
                            n_out_ovf  = 1'b0;
                            n_out_min  = push_min;
                            n_out_minv = 1'b1;
                        end
                    end else if (r_count == '0) begin
                        n_out_valid = 1'b1;
                        n_out_ok    = 1'b0;
                        n_out_pop   = '0;
                        n_out_min   = '0;
                        n_out_minv  = 1'b0;
                        n_out_ovf   = 1'b0;
                    end else begin
                        // fetch the entry that becomes the new top
                        rd_en   = (r_count > CW'(1));
                        n_state = ST_POP;
                    end
                end
            end
            ST_POP: begin
                n_out_valid = 1'b1;
                n_out_ok    = 1'b1;
                n_out_pop   = r_top_val;
                n_out_ovf   = 1'b0;
                n_count     = r_count - CW'(1);
                if (r_count > CW'(1)) begin
                    n_top_val  = rd_val;
                    n_top_min  = rd_min;
                    n_out_min  = rd_min;
                    n_out_minv = 1'b1;
                end else begin
                    n_out_min  = '0;
                    n_out_minv = 1'b0;
                end
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_min, r_out_pop};
    assign o_m_axis_tuser  = {r_out_ovf, r_out_minv, r_out_ok};

endmodule

@@ tb/min_tracking_stack_tb.sv @@
`timescale 1ns / 1ps

module min_tracking_stack_tb;

    import mts_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int PHASE_SWAP  = 640;   // sender idles lightly before, heavily after
    localparam int PHASE_CALM  = 1280;  // no random idling on either side from here
    localparam int HOLD_AT     = 1500;
    localparam int HOLD_CYCLES = 400;
    localparam int N_RUNS      = 9;

    // push share in percent and length of each random run; the high and low shares
    // drive the stack to full and back down to empty
    localparam int RUN_PUSH_PCT [N_RUNS] = '{50, 97, 60, 3, 50, 80, 20, 97, 10};
    localparam int RUN_LEN      [N_RUNS] = '{150, 330, 100, 330, 150, 200, 200, 300, 140};

    typedef struct packed {
        logic               ok;
        logic signed [31:0] popped;
        logic signed [31:0] min_value;
        logic               min_valid;
        logic               overflow;
    } t_stack_outcome;

    typedef struct packed {
        t_kind          op;
        logic [31:0]    operand;
        logic           typed;
        t_stack_outcome outcome;
    } t_directed_row;

    localparam int N_DIRECTED = 23;
    localparam t_directed_row DIRECTED [N_DIRECTED] = '{
        // pop on empty, with operand bits that must be ignored
        '{KIND_POP,  32'h0000_0000, 1'b1, '{1'b0, 32'h0, 32'h0, 1'b0, 1'b0}},
        '{KIND_POP,  32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 32'h0, 1'b0, 1'b0}},
        '{KIND_PUSH, 32'h8000_0000, 1'b1, '{1'b1, 32'h0, 32'h8000_0000, 1'b1, 1'b0}},
        '{KIND_PUSH, 32'h7FFF_FFFF, 1'b1, '{1'b1, 32'h0, 32'h8000_0000, 1'b1, 1'b0}},
        // equal to the current minimum
        '{KIND_PUSH, 32'h8000_0000, 1'b1, '{1'b1, 32'h0, 32'h8000_0000, 1'b1, 1'b0}},
        '{KIND_POP,  32'h0000_0000, 1'b1, '{1'b1, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0}},
        '{KIND_POP,  32'h0000_0000, 1'b1, '{1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0}},
        '{KIND_POP,  32'h0000_0000, 1'b1, '{1'b1, 32'h8000_0000, 32'h0, 1'b0, 1'b0}},
        '{KIND_PUSH, 32'h7FFF_FFFF, 1'b1, '{1'b1, 32'h0, 32'h7FFF_FFFF, 1'b1, 1'b0}},
        '{KIND_PUSH, 32'h0000_0005, 1'b0, '0},
        '{KIND_PUSH, 32'h0000_0005, 1'b0, '0},
        '{KIND_PUSH, 32'hFFFF_FFFF, 1'b0, '0},
        '{KIND_PUSH, 32'h0000_0003, 1'b0, '0},
        '{KIND_PUSH, 32'h8000_0001, 1'b0, '0},
        '{KIND_POP,  32'h5A5A_5A5A, 1'b0, '0},
        '{KIND_POP,  32'hA5A5_A5A5, 1'b0, '0},
        '{KIND_POP,  32'h0000_0000, 1'b0, '0},
        '{KIND_POP,  32'h0000_0000, 1'b0, '0},
        '{KIND_POP,  32'h0000_0000, 1'b0, '0},
        '{KIND_POP,  32'h0000_0000, 1'b1, '{1'b1, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0}},
        '{KIND_POP,  32'h0000_0000, 1'b1, '{1'b0, 32'h0, 32'h0, 1'b0, 1'b0}},
        '{KIND_PUSH, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 32'h0, 1'b1, 1'b0}},
        '{KIND_POP,  32'h0000_0000, 1'b1, '{1'b1, 32'h0, 32'h0, 1'b0, 1'b0}}
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_s_axis_tvalid;
    logic                      o_s_axis_tready;
    logic [DATA_W-1:0]         i_s_axis_tdata;   // push_value
    logic [0:0]                i_s_axis_tuser;   // kind
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready;
    logic [2*DATA_W-1:0]       o_m_axis_tdata;   // popped_value, min_value
    logic [OUT_USER_W-1:0]     o_m_axis_tuser;   // ok, min_valid, overflow

    min_tracking_stack dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // shadow copy of the stack
    logic [31:0]    value_stack [DEPTH_DEF];
    logic [31:0]    min_stack   [DEPTH_DEF];
    int unsigned    stack_depth = 0;

    t_stack_outcome awaited_outcomes [$];
    int             mismatches   = 0;
    int             request_count = 0;
    int             send_idle_pct = 7;
    int             recv_idle_pct = 60;
    int             hold_asked    = 0;

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    initial begin
        #2_400_000;
        $display("FAILURE");
        $finish;
    end

    function automatic t_stack_outcome apply_stack_op(t_kind op, logic [31:0] operand);
        t_stack_outcome res;
        logic [31:0]    new_min;
        res = '0;
        if (op == KIND_PUSH) begin
            if (stack_depth == DEPTH_DEF) begin
                res.overflow = 1'b1;
            end else begin
                new_min = operand;
                if (stack_depth != 0 &&
                    !($signed(operand) < $signed(min_stack[stack_depth-1])))
                    new_min = min_stack[stack_depth-1];
                value_stack[stack_depth] = operand;
                min_stack[stack_depth]   = new_min;
                stack_depth++;
                res.ok = 1'b1;
            end
        end else if (stack_depth != 0) begin
            stack_depth--;
            res.popped = value_stack[stack_depth];
            res.ok     = 1'b1;
        end
        if (stack_depth != 0) begin
            res.min_value = min_stack[stack_depth-1];
            res.min_valid = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return (stack_depth != 0) ? min_stack[stack_depth-1] : 32'd0;
            3:       return 32'(int'($urandom_range(16)) - 8);
            default: return $urandom();
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after the request is taken
    task automatic send_request(input t_kind op, input logic [31:0] operand,
                                input logic typed, input t_stack_outcome typed_outcome);
        t_stack_outcome predicted;
        if (request_count == PHASE_SWAP) begin
            send_idle_pct <= 60;
            recv_idle_pct <= 7;
        end else if (request_count == PHASE_CALM) begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
        end else if (request_count == HOLD_AT) begin
            hold_asked <= hold_asked + 1;
        end
        request_count++;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= operand;
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = apply_stack_op(op, operand);
        awaited_outcomes.push_back(typed ? typed_outcome : predicted);
        @(negedge i_clk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        static int hold_served = 0;
        static int hold_left   = 0;
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_stack_outcome want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (awaited_outcomes.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h / %b",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
                mismatches++;
            end else begin
                want = awaited_outcomes.pop_front();
                check_field("ok", 32'(want.ok), 32'(o_m_axis_tuser[USER_OK]));
                check_field("popped_value", want.popped, o_m_axis_tdata[DATA_W-1:0]);
                check_field("min_value", want.min_value, o_m_axis_tdata[2*DATA_W-1:DATA_W]);
                check_field("min_valid", 32'(want.min_valid), 32'(o_m_axis_tuser[USER_MINV]));
                check_field("overflow", 32'(want.overflow), 32'(o_m_axis_tuser[USER_OVF]));
            end
        end
    end

    initial begin
        t_kind op;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(DIRECTED[i].op, DIRECTED[i].operand,
                         DIRECTED[i].typed, DIRECTED[i].outcome);

        for (int r = 0; r < N_RUNS; r++) begin
            for (int n = 0; n < RUN_LEN[r]; n++) begin
                op = ($urandom_range(99) < RUN_PUSH_PCT[r]) ? KIND_PUSH : KIND_POP;
                send_request(op, (op == KIND_PUSH) ? pick_operand() : $urandom(), 1'b0, '0);
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (awaited_outcomes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
